// ----- sv/ttt_pkg.sv -----
`default_nettype none

package ttt_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned OPCODE_W      = 3;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned COUNT_FIELD_W = 16;
  localparam int unsigned TIME_W        = 27;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_SLOTS      = 16;
  localparam int unsigned DEF_COUNT_BITS = 16;

  // Last tick count of the day; the time of day wraps to zero after it.
  localparam logic [TIME_W-1:0] DAY_END = TIME_W'(86399000);

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ADD      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_SERVICE  = 3'd3,
    OP_SET_TIME = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_REMOVE,
    ST_SERVICE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [SLOT_W-1:0]        slot;
    logic [COUNT_FIELD_W-1:0] initial_delay;
    logic [COUNT_FIELD_W-1:0] period_ticks;
    logic [TIME_W-1:0]        time_value;
  } in_t;

  typedef struct packed {
    logic              status;
    logic              ready_valid;
    logic [SLOT_W-1:0] ready_slot;
    logic              last;
    logic [TIME_W-1:0] time_now;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/ttt_slot_mem.sv -----
`default_nettype none

module ttt_slot_mem #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned IW        = $clog2(SLOTS)
) (
  input  wire logic                  clk_i,
  // Shared read port; the read data is registered.
  input  wire logic                  rd_en_i,
  input  wire logic [IW-1:0]         rd_addr_i,
  output logic      [COUNT_BITS-1:0] rd_count_o,
  output logic      [COUNT_BITS-1:0] rd_period_o,
  output logic      [IW-1:0]         rd_link_o,
  // Countdown and period write port.
  input  wire logic                  data_we_i,
  input  wire logic [IW-1:0]         data_addr_i,
  input  wire logic [COUNT_BITS-1:0] wr_count_i,
  input  wire logic [COUNT_BITS-1:0] wr_period_i,
  // Next-link write port.
  input  wire logic                  link_we_i,
  input  wire logic [IW-1:0]         link_addr_i,
  input  wire logic [IW-1:0]         link_data_i
);

  // Countdown and reload period share one word per slot.
  logic [2*COUNT_BITS-1:0] data_mem [SLOTS];
  logic [IW-1:0]           link_mem [SLOTS];
  logic [2*COUNT_BITS-1:0] data_rd_q;
  logic [IW-1:0]           link_rd_q;

  // Data memory.
  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      data_mem[data_addr_i] <= {wr_count_i, wr_period_i};
    end
    if (rd_en_i) begin
      data_rd_q <= data_mem[rd_addr_i];
    end
  end

  // Link memory.
  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_addr_i] <= link_data_i;
    end
    if (rd_en_i) begin
      link_rd_q <= link_mem[rd_addr_i];
    end
  end

  assign rd_count_o  = data_rd_q[2*COUNT_BITS-1:COUNT_BITS];
  assign rd_period_o = data_rd_q[COUNT_BITS-1:0];
  assign rd_link_o   = link_rd_q;

endmodule

`default_nettype wire

// ----- sv/tick_task_timer_table.sv -----
`default_nettype none

// Tick-driven timer table. Slots are kept in a linked list in the order they
// were added; countdown, reload period and next link of each slot live in a
// slot memory with a registered read, while the listed and fire flags sit in
// flip-flops. Add, set time, rejected and unknown requests walk no slots and
// go straight to their result. Tick walks the list one slot per cycle. Remove
// walks from the head to the slot. Service walks from the head up to the last
// fired slot, one slot per cycle while the result side does not stall, and
// gives one result per fired slot; with nothing fired it gives one result.
// The walk speed is set by the single read port of the slot memory, since
// each step needs the link read in the step before. A new request is taken
// only while no request is in progress; the result register lets it be taken
// while an earlier result still waits downstream.
module tick_task_timer_table
  import ttt_pkg::*;
#(
  parameter int unsigned SLOTS      = DEF_SLOTS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CNTW = $clog2(SLOTS + 1);

  state_e                state_q, state_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic [IW-1:0]         prev_q, prev_d;
  logic                  has_prev_q, has_prev_d;
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [CNTW-1:0]       rem_q, rem_d;
  logic [IW-1:0]         head_q, head_d;
  logic [IW-1:0]         tail_q, tail_d;
  logic [CNTW-1:0]       count_q, count_d;
  logic [SLOTS-1:0]      listed_q, listed_d;
  logic [SLOTS-1:0]      fire_q, fire_d;
  logic [TIME_W-1:0]     tod_q, tod_d;
  logic                  status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  // Slot memory controls.
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] cd_rd, per_rd;
  logic [IW-1:0]         link_rd;
  logic                  data_we;
  logic [IW-1:0]         data_addr;
  logic [COUNT_BITS-1:0] wr_count, wr_period;
  logic                  link_we;
  logic [IW-1:0]         link_addr, link_data;

  logic                  in_acc, out_free, load_out, do_unlink;
  op_e                   op;
  logic                  slot_ok, add_ok, rm_ok;
  logic [IW-1:0]         slot_idx;
  logic [SLOTS-1:0]      fire_rest;
  logic                  more_fired, cur_fired;
  logic [COUNT_BITS-1:0] cd_dec, cd_new;
  logic                  tick_fire;

  ttt_slot_mem #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_slot_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_count_o  (cd_rd),
    .rd_period_o (per_rd),
    .rd_link_o   (link_rd),
    .data_we_i   (data_we),
    .data_addr_i (data_addr),
    .wr_count_i  (wr_count),
    .wr_period_i (wr_period),
    .link_we_i   (link_we),
    .link_addr_i (link_addr),
    .link_data_i (link_data)
  );

  // Handshake and request decode.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign op         = op_e'(in_i.opcode);
  assign slot_ok    = 32'(in_i.slot) < SLOTS;
  assign slot_idx   = IW'(in_i.slot);
  assign add_ok     = slot_ok && !listed_q[slot_idx] && (count_q < CNTW'(SLOTS));
  assign rm_ok      = slot_ok && listed_q[slot_idx];

  // Fired slots other than the current one; every fired slot is listed and
  // not yet visited, so none left means the current result is the last.
  always_comb begin
    fire_rest        = fire_q;
    fire_rest[cur_q] = 1'b0;
  end
  assign more_fired = |fire_rest;
  assign cur_fired  = fire_q[cur_q];

  // Countdown step for one slot during a tick.
  assign cd_dec    = (cd_rd != '0) ? cd_rd - COUNT_BITS'(1) : '0;
  assign tick_fire = (cd_dec == '0);
  assign cd_new    = (tick_fire && per_rd != '0) ? per_rd : cd_dec;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_TICK:    state_d = (count_q != '0) ? ST_TICK : ST_EMIT;
            OP_REMOVE:  state_d = rm_ok ? ST_REMOVE : ST_EMIT;
            OP_SERVICE: state_d = (|fire_q) ? ST_SERVICE : ST_EMIT;
            default:    state_d = ST_EMIT;
          endcase
        end
      end
      ST_TICK: begin
        if (rem_q <= CNTW'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_REMOVE: begin
        if (cur_q == tgt_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_SERVICE: begin
        if (cur_fired && out_free && !more_fired) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and results.
  always_comb begin
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    tgt_d      = tgt_q;
    rem_d      = rem_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    listed_d   = listed_q;
    fire_d     = fire_q;
    tod_d      = tod_q;
    status_d   = status_q;
    out_d      = out_q;
    load_out   = 1'b0;
    do_unlink  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    data_we    = 1'b0;
    data_addr  = cur_q;
    wr_count   = cd_new;
    wr_period  = per_rd;
    link_we    = 1'b0;
    link_addr  = tail_q;
    link_data  = slot_idx;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          status_d   = STATUS_OK;
          prev_d     = '0;
          has_prev_d = 1'b0;
          cur_d      = head_q;
          case (op)
            OP_TICK: begin
              tod_d = (tod_q >= DAY_END) ? '0 : tod_q + TIME_W'(1);
              rem_d = count_q;
              if (count_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
              end
            end
            OP_ADD: begin
              if (add_ok) begin
                data_we   = 1'b1;
                data_addr = slot_idx;
                wr_count  = COUNT_BITS'(in_i.initial_delay);
                wr_period = COUNT_BITS'(in_i.period_ticks);
                listed_d[slot_idx] = 1'b1;
                fire_d[slot_idx]   = 1'b0;
                if (count_q == '0) begin
                  head_d = slot_idx;
                end else begin
                  link_we = 1'b1;
                end
                tail_d  = slot_idx;
                count_d = count_q + CNTW'(1);
              end else begin
                status_d = STATUS_REJECT;
              end
            end
            OP_REMOVE: begin
              tgt_d = slot_idx;
              if (rm_ok) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
              end else begin
                status_d = STATUS_REJECT;
              end
            end
            OP_SERVICE: begin
              if (|fire_q) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
              end
            end
            OP_SET_TIME: begin
              tod_d = (in_i.time_value > DAY_END) ? '0 : in_i.time_value;
            end
            default: status_d = STATUS_REJECT;
          endcase
        end
      end

      // Count down the current slot and fetch the next one.
      ST_TICK: begin
        data_we = 1'b1;
        if (tick_fire) begin
          fire_d[cur_q] = 1'b1;
        end
        if (rem_q > CNTW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
          cur_d   = link_rd;
          rem_d   = rem_q - CNTW'(1);
        end
      end

      // Search for the slot to remove, keeping its predecessor.
      ST_REMOVE: begin
        if (cur_q == tgt_q) begin
          do_unlink = 1'b1;
        end else begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = link_rd;
          cur_d      = link_rd;
        end
      end

      // Emit fired slots in list order; hold the slot while the result
      // register is full by reading it again.
      ST_SERVICE: begin
        if (cur_fired) begin
          if (out_free) begin
            load_out          = 1'b1;
            out_d.status      = STATUS_OK;
            out_d.ready_valid = 1'b1;
            out_d.ready_slot  = SLOT_W'(cur_q);
            out_d.last        = !more_fired;
            out_d.time_now    = tod_q;
            fire_d[cur_q]     = 1'b0;
            if (per_rd == '0) begin
              do_unlink = 1'b1;
            end else begin
              prev_d     = cur_q;
              has_prev_d = 1'b1;
            end
            if (more_fired) begin
              rd_en   = 1'b1;
              rd_addr = link_rd;
              cur_d   = link_rd;
            end
          end else begin
            rd_en = 1'b1;
          end
        end else begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = link_rd;
          cur_d      = link_rd;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_d.status      = status_q;
          out_d.ready_valid = 1'b0;
          out_d.ready_slot  = '0;
          out_d.last        = 1'b1;
          out_d.time_now    = tod_q;
        end
      end

      default: ;
    endcase

    // Unlink the current slot; a removed tail keeps its predecessor's stale
    // link, which the count-bounded walks never follow.
    if (do_unlink) begin
      listed_d[cur_q] = 1'b0;
      fire_d[cur_q]   = 1'b0;
      count_d         = count_q - CNTW'(1);
      if (count_q <= CNTW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else if (!has_prev_q) begin
        head_d = link_rd;
      end else if (cur_q == tail_q) begin
        tail_d = prev_q;
      end else begin
        link_we   = 1'b1;
        link_addr = prev_q;
        link_data = link_rd;
      end
    end

    out_valid_d = load_out ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      listed_q    <= '0;
      fire_q      <= '0;
      tod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      listed_q    <= listed_d;
      fire_q      <= fire_d;
      tod_q       <= tod_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    has_prev_q <= has_prev_d;
    tgt_q      <= tgt_d;
    rem_q      <= rem_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Only listed slots can carry a fire flag.
  a_fire_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_q & ~listed_q) == '0)
    else $error("fire flag set on a slot that is not listed");

  // The list length matches the number of listed slots.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNTW'($countones(listed_q)))
    else $error("list count disagrees with listed flags");

  // Every list walk only visits listed slots.
  a_walk_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK || state_q == ST_REMOVE || state_q == ST_SERVICE)
      |-> listed_q[cur_q])
    else $error("list walk reached a slot that is not listed");

  // The data memory never reads and writes the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && data_we) |-> (rd_addr != data_addr))
    else $error("read and write of the same slot entry in one cycle");

  // The time of day stays within one day.
  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tod_q <= DAY_END)
    else $error("time of day beyond the end of the day");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RANDOM_REQS = 380;
  localparam logic [OPCODE_W-1:0] OP_FIRST_SPARE = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_LAST_SPARE  = 3'd7;

  // Scoreboard: keeps its own copy of the timer table and the queue of
  // results that the accepted requests are due to produce.
  class timer_table_scoreboard;
    logic [COUNT_FIELD_W-1:0] countdown [DEF_SLOTS];
    logic [COUNT_FIELD_W-1:0] period    [DEF_SLOTS];
    bit                       fired     [DEF_SLOTS];
    bit                       listed    [DEF_SLOTS];
    logic [SLOT_W-1:0]        link      [DEF_SLOTS];
    logic [SLOT_W-1:0]        head;
    logic [SLOT_W-1:0]        tail;
    int unsigned              count;
    logic [TIME_W-1:0]        time_of_day;
    out_t                     due_results [$];
    int unsigned              mismatches;

    function new();
      for (int i = 0; i < DEF_SLOTS; i++) begin
        countdown[i] = '0;
        period[i]    = '0;
        fired[i]     = 1'b0;
        listed[i]    = 1'b0;
        link[i]      = '0;
      end
      head        = '0;
      tail        = '0;
      count       = 0;
      time_of_day = '0;
      mismatches  = 0;
    endfunction

    function void queue_result(logic status, logic valid, logic [SLOT_W-1:0] slot,
                               logic last);
      out_t r;
      r.status      = status;
      r.ready_valid = valid;
      r.ready_slot  = slot;
      r.last        = last;
      r.time_now    = time_of_day;
      due_results.push_back(r);
    endfunction

    // Takes slot s out of the list; prev is its predecessor when has_prev is set.
    function void unlink(logic [SLOT_W-1:0] s, logic [SLOT_W-1:0] prev, bit has_prev);
      if (count <= 1) begin
        head = '0;
        tail = '0;
      end else if (!has_prev) begin
        head = link[s];
      end else if (s == tail) begin
        tail = prev;
      end else begin
        link[prev] = link[s];
      end
      if (count > 0) count--;
      listed[s] = 1'b0;
      fired[s]  = 1'b0;
    endfunction

    // Applies one accepted request to the table and queues its results.
    function void note_request(in_t req);
      logic [SLOT_W-1:0] cur;
      logic [SLOT_W-1:0] prev;
      logic [SLOT_W-1:0] nxt;
      logic [SLOT_W-1:0] due_slots [$];
      bit                has_prev;
      int unsigned       n;
      case (req.opcode)
        OP_TICK: begin
          cur = head;
          for (int unsigned i = 0; i < count; i++) begin
            if (countdown[cur] != 0) countdown[cur]--;
            if (countdown[cur] == 0) begin
              fired[cur] = 1'b1;
              if (period[cur] != 0) countdown[cur] = period[cur];
            end
            if (i + 1 < count) cur = link[cur];
          end
          if (time_of_day >= DAY_END) time_of_day = '0;
          else time_of_day = time_of_day + 1'b1;
          queue_result(STATUS_OK, 1'b0, '0, 1'b1);
        end
        OP_ADD: begin
          if (listed[req.slot] || count >= DEF_SLOTS) begin
            queue_result(STATUS_REJECT, 1'b0, '0, 1'b1);
          end else begin
            countdown[req.slot] = req.initial_delay;
            period[req.slot]    = req.period_ticks;
            fired[req.slot]     = 1'b0;
            listed[req.slot]    = 1'b1;
            if (count == 0) head = req.slot;
            else link[tail] = req.slot;
            tail = req.slot;
            count++;
            queue_result(STATUS_OK, 1'b0, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (!listed[req.slot]) begin
            queue_result(STATUS_REJECT, 1'b0, '0, 1'b1);
          end else begin
            cur      = head;
            prev     = '0;
            has_prev = 1'b0;
            for (int unsigned i = 0; i < count && cur != req.slot; i++) begin
              prev     = cur;
              has_prev = 1'b1;
              cur      = link[cur];
            end
            unlink(req.slot, prev, has_prev);
            queue_result(STATUS_OK, 1'b0, '0, 1'b1);
          end
        end
        OP_SERVICE: begin
          n        = count;
          cur      = head;
          prev     = '0;
          has_prev = 1'b0;
          for (int unsigned i = 0; i < n; i++) begin
            nxt = (i + 1 < n) ? link[cur] : '0;
            if (fired[cur]) begin
              due_slots.push_back(cur);
              fired[cur] = 1'b0;
              // One-shot slots leave the list once served.
              if (period[cur] == 0) begin
                unlink(cur, prev, has_prev);
              end else begin
                prev     = cur;
                has_prev = 1'b1;
              end
            end else begin
              prev     = cur;
              has_prev = 1'b1;
            end
            cur = nxt;
          end
          if (due_slots.size() == 0) begin
            queue_result(STATUS_OK, 1'b0, '0, 1'b1);
          end else begin
            foreach (due_slots[i])
              queue_result(STATUS_OK, 1'b1, due_slots[i], i == due_slots.size() - 1);
          end
        end
        OP_SET_TIME: begin
          if (req.time_value > DAY_END) time_of_day = '0;
          else time_of_day = req.time_value;
          queue_result(STATUS_OK, 1'b0, '0, 1'b1);
        end
        default: begin
          queue_result(STATUS_REJECT, 1'b0, '0, 1'b1);
        end
      endcase
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
        $display("mismatch: %s: got %0d, expected %0d", what, got, want);
    endfunction

    // Compares one accepted result with the oldest one still due.
    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report("result with none due, ready_slot", 32'(got.ready_slot), 0);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.ready_valid !== want.ready_valid)
        report("ready_valid", 32'(got.ready_valid), 32'(want.ready_valid));
      if (got.ready_slot !== want.ready_slot)
        report("ready_slot", 32'(got.ready_slot), 32'(want.ready_slot));
      if (got.last !== want.last)
        report("last", 32'(got.last), 32'(want.last));
      if (got.time_now !== want.time_now)
        report("time_now", 32'(got.time_now), 32'(want.time_now));
    endfunction
  endclass

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  timer_table_scoreboard sb = new();

  int unsigned cycle_count  = 0;
  int unsigned hold_asked   = 0;
  int unsigned hold_started = 0;
  int unsigned hold_left    = 0;
  logic [31:0] rx_cycles    = '0;
  int unsigned rx_mode      = 0;

  tick_task_timer_table u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next ready level.
  // A requested long hold-off is counted here; otherwise the stall pattern
  // changes whenever the low six bits of rx_cycles wrap to zero.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) sb.check_result(out_data);
    rx_cycles++;
    if (rx_cycles[5:0] == 6'd0) rx_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_started != hold_asked) begin
      hold_started++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_cycles[2] ^ rx_cycles[0];
      endcase
    end
  end

  function automatic in_t make_req(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
                                   logic [COUNT_FIELD_W-1:0] delay,
                                   logic [COUNT_FIELD_W-1:0] per,
                                   logic [TIME_W-1:0] tv);
    in_t req;
    req.opcode        = op;
    req.slot          = slot;
    req.initial_delay = delay;
    req.period_ticks  = per;
    req.time_value    = tv;
    return req;
  endfunction

  // Mostly a slot that is (or is not) in the list, so that adds and removes
  // usually succeed; now and then any slot.
  function automatic logic [SLOT_W-1:0] choose_slot(bit want_listed);
    logic [SLOT_W-1:0] candidates [$];
    for (int i = 0; i < DEF_SLOTS; i++)
      if (sb.listed[i] == want_listed) candidates.push_back(SLOT_W'(i));
    if (candidates.size() != 0 && $urandom_range(0, 3) != 0)
      return candidates[$urandom_range(0, candidates.size() - 1)];
    return SLOT_W'($urandom_range(0, DEF_SLOTS - 1));
  endfunction

  // Random request: fields that do not apply carry random bits.
  function automatic in_t random_request();
    in_t         req;
    int unsigned pick;
    int unsigned r;
    req.opcode        = OP_TICK;
    req.slot          = SLOT_W'($urandom_range(0, DEF_SLOTS - 1));
    req.initial_delay = COUNT_FIELD_W'($urandom);
    req.period_ticks  = COUNT_FIELD_W'($urandom);
    req.time_value    = TIME_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      req.opcode = OP_TICK;
    end else if (pick < 58) begin
      req.opcode = OP_ADD;
      req.slot   = choose_slot(1'b0);
      r = $urandom_range(0, 19);
      if (r == 0) req.initial_delay = '0;
      else if (r == 1) req.initial_delay = '1;
      else if (r >= 4) req.initial_delay = COUNT_FIELD_W'($urandom_range(1, 6));
      r = $urandom_range(0, 9);
      if (r < 4) req.period_ticks = '0;
      else if (r < 8) req.period_ticks = COUNT_FIELD_W'($urandom_range(1, 8));
    end else if (pick < 70) begin
      req.opcode = OP_REMOVE;
      req.slot   = choose_slot(1'b1);
    end else if (pick < 90) begin
      req.opcode = OP_SERVICE;
    end else if (pick < 97) begin
      req.opcode = OP_SET_TIME;
      r = $urandom_range(0, 3);
      if (r == 1) req.time_value = DAY_END - TIME_W'($urandom_range(0, 3));
      else if (r == 2) req.time_value = DAY_END + TIME_W'($urandom_range(1, 3));
      else if (r == 3) req.time_value = TIME_W'($urandom_range(0, DAY_END));
    end else begin
      req.opcode = OPCODE_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
    end
    return req;
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic offer_request(in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
  endtask

  initial begin
    in_t         directed [$];
    in_t         req;
    int unsigned n_dir;
    int unsigned total;
    int unsigned burst_left;
    int unsigned gap;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed opening: empty table, rejections, extremes, a zero countdown
    // that keeps firing, one-shot drop, spare opcodes and the day wrap.
    directed.push_back(make_req(OP_SERVICE, '0, '0, '0, '0));
    directed.push_back(make_req(OP_TICK, '0, '0, '0, '0));
    directed.push_back(make_req(OP_REMOVE, 4'd5, '0, '0, '0));
    directed.push_back(make_req(OP_ADD, 4'd0, 16'd1, '0, '0));
    directed.push_back(make_req(OP_ADD, 4'd15, '1, '1, '0));
    directed.push_back(make_req(OP_ADD, 4'd0, 16'd3, 16'd3, '0));
    directed.push_back(make_req(OP_ADD, 4'd7, '0, 16'd2, '0));
    directed.push_back(make_req(OP_ADD, 4'd3, 16'd2, 16'd1, '0));
    directed.push_back(make_req(OP_TICK, '0, '0, '0, '0));
    directed.push_back(make_req(OP_TICK, '0, '0, '0, '0));
    directed.push_back(make_req(OP_SERVICE, '0, '0, '0, '0));
    directed.push_back(make_req(OP_SERVICE, '0, '0, '0, '0));
    directed.push_back(make_req(OP_REMOVE, 4'd15, '0, '0, '0));
    directed.push_back(make_req(OP_REMOVE, 4'd3, '0, '0, '0));
    directed.push_back(make_req(OP_ADD, 4'd15, 16'd1, '0, '0));
    directed.push_back(make_req(OP_FIRST_SPARE, 4'd10, '1, '1, '1));
    directed.push_back(make_req(OP_FIRST_SPARE + 3'd1, '0, '0, '0, '0));
    directed.push_back(make_req(OP_LAST_SPARE, 4'd6, 16'h5A5A, 16'hA5A5, '0));
    directed.push_back(make_req(OP_SET_TIME, '0, '0, '0, '1));
    directed.push_back(make_req(OP_SET_TIME, '0, '0, '0, DAY_END));
    directed.push_back(make_req(OP_TICK, '0, '0, '0, '0));
    directed.push_back(make_req(OP_TICK, '0, '0, '0, '0));
    directed.push_back(make_req(OP_SERVICE, '0, '0, '0, '0));

    n_dir      = directed.size();
    total      = n_dir + RANDOM_REQS;
    burst_left = 0;
    for (int unsigned k = 0; k < total; k++) begin
      // Bursts of random length, with random gaps between them.
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      // Long result hold-off while requests keep coming.
      if (k == n_dir + 120 || k == n_dir + 300) hold_asked <= hold_asked + 1;
      // Let the block drain completely once.
      if (k == n_dir + 240 && sb.due_results.size() != 0) begin
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
      end
      req = (k < n_dir) ? directed[k] : random_request();
      offer_request(req);
    end
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ttt_pkg.sv
sv/ttt_slot_mem.sv
sv/tick_task_timer_table.sv
tb/sv/tb_top.sv
